// File: src/hex_dump_int16_vector_parser_assert.svh
// Assertion macros for the RTL. Clock is clk_i, reset is rst_ni (active low).
`ifndef HEX_DUMP_INT16_VECTOR_PARSER_ASSERT_SVH
`define HEX_DUMP_INT16_VECTOR_PARSER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define HDP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hdp assertion failed");

// Consequent checked in the cycle after the antecedent
`define HDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hdp assertion failed");

`endif

// File: src/hdp_pkg.sv
package hdp_pkg;

  // Dump geometry
  localparam int unsigned DumpBytes     = 6;
  localparam int unsigned QueueDepthDef = 2;
  localparam logic [15:0] ScaleReset    = 16'd1;

  // Separator characters
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  // One parse outcome handed from front to back
  typedef struct packed {
    logic                          ok;
    logic [DumpBytes-1:0][7:0]     bytes;
  } hdp_entry_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

  // Returns {is_digit, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

// File: src/hex_dump_int16_vector_parser.sv
// Hex dump to three-axis vector parser. Takes one character per clock on the slave stream
// (tuser flags the first character of a dump) and, once six space/tab/CR/LF separated hex bytes
// are complete, returns one word: three little-endian signed 16-bit axes times lsb_scale
// (APB register at address 0, reset 1); a malformed or short dump returns one word with the
// valid flag clear and zero axes. A result word passes through the result queue and the output
// register before it leaves the master stream; the parser, a QueueDepth-entry result queue and
// the output register let characters keep flowing at one per clock while up to QueueDepth result
// words wait downstream. Write lsb_scale only while no dump result is outstanding.
module hex_dump_int16_vector_parser #(
  parameter int unsigned QueueDepth = hdp_pkg::QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Character stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]   s_axis_tuser,   // [0] first_char
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // [31:0] axis_x, [63:32] axis_y, [95:64] axis_z
  output logic [0:0]   m_axis_tuser,   // [0] valid_dump
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import hdp_pkg::*;

  logic               q_ready, push, pop, head_valid;
  hdp_entry_t         entry, head;
  logic [15:0]        lsb_scale_q;
  logic signed [31:0] ax, ay, az;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsb_scale_q <= ScaleReset;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      lsb_scale_q <= pwdata[15:0];
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {16'd0, lsb_scale_q};

  hdp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .char_code_i  (s_axis_tdata),
    .first_char_i (s_axis_tuser[0]),
    .q_ready_i    (q_ready),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .entry_o      (entry)
  );

  hdp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (entry),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  hdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .lsb_scale_i  (lsb_scale_q),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .valid_dump_o (m_axis_tuser[0]),
    .axis_x_o     (ax),
    .axis_y_o     (ay),
    .axis_z_o     (az)
  );

  assign m_axis_tdata = {az, ay, ax};

endmodule

// File: src/hdp_front.sv
module hdp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          char_code_i,
  input  logic                first_char_i,
  input  logic                q_ready_i,
  output logic                in_ready_o,
  output logic                push_o,
  output hdp_pkg::hdp_entry_t entry_o
);
  import hdp_pkg::*;

  typedef enum logic [3:0] {
    PH_DONE = 4'b0001,
    PH_SEP  = 4'b0010,
    PH_ONE  = 4'b0100,
    PH_TWO  = 4'b1000
  } hdp_phase_e;

  localparam logic [2:0] LastByte = 3'(DumpBytes - 1);

  hdp_phase_e phase_q, phase_d, phase_eff;
  logic [2:0] count_q, count_d, count_eff;
  logic [7:0] part_q, part_d, part_eff;
  logic [7:0] store_q [DumpBytes];
  logic       store_we;
  logic       accept;
  logic       sep;
  logic [4:0] dig;
  logic       end_tok, fail;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign sep        = is_sep(char_code_i);
  assign dig        = hex_digit(char_code_i);

  // A first character restarts the parse before it is examined
  assign phase_eff = first_char_i ? PH_SEP : phase_q;
  assign count_eff = first_char_i ? 3'd0 : count_q;
  assign part_eff  = first_char_i ? 8'd0 : part_q;

  // Token parsing
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    part_d   = part_q;
    end_tok  = 1'b0;
    fail     = 1'b0;
    store_we = 1'b0;
    push_o   = 1'b0;
    entry_o  = '0;
    if (accept) begin
      phase_d = phase_eff;
      count_d = count_eff;
      part_d  = part_eff;
      case (phase_eff)
        PH_SEP: begin
          if (!sep) begin
            if (dig[4]) begin
              part_d  = {4'd0, dig[3:0]};
              phase_d = PH_ONE;
            end else begin
              fail = 1'b1;
            end
          end
        end
        PH_ONE: begin
          if (dig[4]) begin
            part_d  = {part_eff[3:0], dig[3:0]};
            phase_d = PH_TWO;
          end else begin
            end_tok = 1'b1;
          end
        end
        PH_TWO: begin
          if (dig[4]) fail = 1'b1;
          else end_tok = 1'b1;
        end
        PH_DONE: ;
        default: phase_d = PH_DONE;
      endcase

      // Byte complete: store it, then finish or carry on
      if (end_tok) begin
        store_we = 1'b1;
        count_d  = count_eff + 3'd1;
        part_d   = 8'd0;
        if (count_eff == LastByte) begin
          push_o     = 1'b1;
          entry_o.ok = 1'b1;
          for (int i = 0; i < DumpBytes - 1; i++) entry_o.bytes[i] = store_q[i];
          entry_o.bytes[DumpBytes-1] = part_eff;
          phase_d    = PH_DONE;
        end else if (sep) begin
          phase_d = PH_SEP;
        end else begin
          fail = 1'b1;
        end
      end

      if (fail) begin
        push_o  = 1'b1;
        entry_o = '0;
        phase_d = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      count_q <= 3'd0;
      part_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      part_q  <= part_d;
    end
  end

  // Byte store, no reset: each entry is written before the dump reads it
  always_ff @(posedge clk_i) begin
    if (store_we && count_eff != LastByte) store_q[count_eff] <= part_eff;
  end

endmodule

// File: src/hdp_queue.sv
`include "hex_dump_int16_vector_parser_assert.svh"

module hdp_queue #(
  parameter int unsigned Depth = hdp_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hdp_pkg::hdp_entry_t push_entry_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output hdp_pkg::hdp_entry_t head_o
);
  import hdp_pkg::*;

  // Depth of 2 or more
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hdp_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign ready_o      = count_q != CntW'(Depth);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_q];
  assign push         = push_i && ready_o;
  assign pop          = pop_i && head_valid_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) wr_q <= next_ptr(wr_q);
      if (pop) rd_q <= next_ptr(rd_q);
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  // Word storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_entry_i;
  end

  `HDP_ASSERT_SAME(a_pop_not_empty, pop_i, count_q != '0)
  `HDP_ASSERT_NEXT(a_fill_up, push && !pop, count_q == $past(count_q) + 1'b1)
  `HDP_ASSERT_NEXT(a_fill_down, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

// File: src/hdp_back.sv
module hdp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  hdp_pkg::hdp_entry_t head_i,
  input  logic [15:0]         lsb_scale_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                valid_dump_o,
  output logic signed [31:0]  axis_x_o,
  output logic signed [31:0]  axis_y_o,
  output logic signed [31:0]  axis_z_o
);
  import hdp_pkg::*;

  logic               out_valid_q;
  logic               ok_q;
  logic signed [31:0] x_q, y_q, z_q;

  // Little-endian signed 16-bit value times unsigned scale, low 32 bits
  function automatic logic signed [31:0] scale_axis(input logic [7:0] lo,
                                                     input logic [7:0] hi,
                                                     input logic [15:0] s);
    logic signed [32:0] p;
    p = $signed({hi, lo}) * $signed({1'b0, s});
    return p[31:0];
  endfunction

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q <= head_i.ok;
      x_q  <= scale_axis(head_i.bytes[0], head_i.bytes[1], lsb_scale_i);
      y_q  <= scale_axis(head_i.bytes[2], head_i.bytes[3], lsb_scale_i);
      z_q  <= scale_axis(head_i.bytes[4], head_i.bytes[5], lsb_scale_i);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign valid_dump_o = ok_q;
  assign axis_x_o     = x_q;
  assign axis_y_o     = y_q;
  assign axis_z_o     = z_q;

endmodule

// File: tb/sv/tb.sv
module tb;
  import hdp_pkg::*;

  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam logic [2:0]  SCALE_ADDR    = 3'd0;
  localparam logic [2:0]  SPARE_ADDR    = 3'd4;
  localparam logic [7:0]  CH_NUL        = 8'h00;

  typedef enum logic [1:0] {
    PS_DONE,
    PS_GAP,
    PS_ONE_DIGIT,
    PS_TWO_DIGITS
  } parse_state_e;

  // One character word for the slave stream
  typedef struct {
    logic [7:0] ch;
    logic       first;
  } char_word_t;

  // One predicted result word
  typedef struct {
    logic        ok;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vector_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  hex_dump_int16_vector_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  char_word_t   char_queue[$];
  vector_t      vector_queue[$];
  int unsigned  fail_count = 0;
  int unsigned  items_pushed = 0;
  int unsigned  cycle_count = 0;
  logic         mark_first = 1'b0;
  logic         no_gaps = 1'b0;

  // Parser copy: state and scale register
  parse_state_e cur_phase = PS_DONE;
  logic [2:0]   byte_count = 3'd0;
  logic [7:0]   token_acc = 8'd0;
  logic [7:0]   dump_bytes[DumpBytes];
  logic [15:0]  scale_now = ScaleReset;

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
  endfunction

  function automatic logic digit_value(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'd0;
    if (c >= "0" && c <= "9") begin
      nib = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      nib = 4'(c - "a" + 10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      nib = 4'(c - "A" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Little-endian int16 times the scale, kept to 32 bits
  function automatic logic [31:0] scaled_axis(input logic [7:0] lo, input logic [7:0] hi);
    logic signed [15:0] raw;
    longint             prod;
    raw  = {hi, lo};
    prod = longint'(raw) * longint'({48'd0, scale_now});
    return prod[31:0];
  endfunction

  // Advance the parser copy by one character; returns 1 when a result word is due
  function automatic logic parse_char(input logic [7:0] c, input logic first,
                                      output vector_t res);
    logic       dig;
    logic [3:0] nib;
    res.ok = 1'b0;
    res.x  = 32'd0;
    res.y  = 32'd0;
    res.z  = 32'd0;
    dig = digit_value(c, nib);
    if (first) begin
      cur_phase  = PS_GAP;
      byte_count = 3'd0;
      token_acc  = 8'd0;
    end
    case (cur_phase)
      PS_GAP: begin
        if (is_blank(c)) return 1'b0;
        if (!dig) begin
          cur_phase = PS_DONE;
          return 1'b1;
        end
        token_acc = {4'd0, nib};
        cur_phase = PS_ONE_DIGIT;
        return 1'b0;
      end
      PS_ONE_DIGIT: begin
        if (dig) begin
          token_acc = {token_acc[3:0], nib};
          cur_phase = PS_TWO_DIGITS;
          return 1'b0;
        end
      end
      PS_TWO_DIGITS: begin
        if (dig) begin
          cur_phase = PS_DONE;
          return 1'b1;
        end
      end
      default: return 1'b0;
    endcase
    // token closed by a non-digit
    if (byte_count < DumpBytes) dump_bytes[byte_count] = token_acc;
    byte_count = byte_count + 3'd1;
    token_acc  = 8'd0;
    if (byte_count >= DumpBytes) begin
      res.ok    = 1'b1;
      res.x     = scaled_axis(dump_bytes[0], dump_bytes[1]);
      res.y     = scaled_axis(dump_bytes[2], dump_bytes[3]);
      res.z     = scaled_axis(dump_bytes[4], dump_bytes[5]);
      cur_phase = PS_DONE;
      return 1'b1;
    end
    if (is_blank(c)) begin
      cur_phase = PS_GAP;
      return 1'b0;
    end
    cur_phase = PS_DONE;
    return 1'b1;
  endfunction

  // Character driver: register update and prediction on each accepted word
  always @(posedge clk_i or negedge rst_ni) begin : char_driver
    vector_t    res;
    char_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SCALE_ADDR) begin
        scale_now = pwdata[15:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_char(s_axis_tdata, s_axis_tuser[0], res)) vector_queue.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 22)) begin
          w = char_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.ch;
          s_axis_tuser  <= w.first;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : vector_monitor
    vector_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (vector_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual tuser %h tdata %h",
                   $time, m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = vector_queue.pop_front();
          check_field("valid_dump", {31'd0, want.ok}, {31'd0, m_axis_tuser[0]});
          check_field("axis_x", want.x, m_axis_tdata[31:0]);
          check_field("axis_y", want.y, m_axis_tdata[63:32]);
          check_field("axis_z", want.z, m_axis_tdata[95:64]);
        end
      end
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 22);
    end
  end

  // Stimulus helpers
  task automatic push_char(input logic [7:0] c);
    char_queue.push_back('{ch: c, first: mark_first});
    mark_first = 1'b0;
    items_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChLf;
      default: return ChCr;
    endcase
  endfunction

  // Neither a hex digit nor a separator; NUL and top-bit codes included
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    logic [3:0] nib;
    if ($urandom_range(5) == 0) return CH_NUL;
    do begin
      c = 8'($urandom_range(255));
    end while (digit_value(c, nib) || is_blank(c));
    return c;
  endfunction

  task automatic push_blanks(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) push_char(blank_char());
  endtask

  task automatic push_token();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(3) != 0) push_char(hex_char(b[7:4]));
    push_char(hex_char(b[3:0]));
  endtask

  task automatic push_tokens(input int n);
    for (int i = 0; i < n; i++) begin
      if (i != 0) push_blanks(1, 3);
      push_token();
    end
  endtask

  task automatic good_dump();
    mark_first = 1'b1;
    push_blanks(0, 2);
    push_tokens(DumpBytes);
    if ($urandom_range(4) < 2) push_char(blank_char());
    else push_char(junk_char());
    // trailing characters after the result are ignored
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) push_char(8'($urandom_range(255)));
  endtask

  task automatic broken_dump();
    mark_first = 1'b1;
    push_blanks(0, 1);
    push_tokens($urandom_range(5));
    case ($urandom_range(2))
      0: begin
        // short dump ended by junk
        if ($urandom_range(1)) push_char(blank_char());
        push_char(junk_char());
      end
      1: begin
        // third digit in one token
        if ($urandom_range(1)) push_char(blank_char());
        repeat (3) push_char(hex_char(4'($urandom_range(15))));
      end
      default: begin
        // left open; the next dump restarts it
        if ($urandom_range(1)) push_char(hex_char(4'($urandom_range(15))));
      end
    endcase
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(8, 3);
    repeat (n) begin
      mark_first = ($urandom_range(3) == 0);
      push_char(8'($urandom_range(255)));
    end
  endtask

  task automatic fill_random(input int unsigned n);
    int unsigned target;
    int          pick;
    target = items_pushed + n;
    while (items_pushed < target) begin
      pick = $urandom_range(99);
      if (pick < 70) good_dump();
      else if (pick < 90) broken_dump();
      else noise_burst();
    end
    good_dump();
  endtask

  task automatic wait_idle();
    while (char_queue.size() != 0 || s_axis_tvalid || vector_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] a, input logic [15:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= {16'($urandom), d};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] a);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== scale_now) begin
      $display("%0t: lsb_scale readback mismatch, expected %h, actual %h",
               $time, scale_now, prdata[15:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Main sequence
  initial begin : main_seq
    logic [15:0] scale_pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes: -32768, 32767 and -1, every separator, NUL ending
    mark_first = 1'b1;
    push_text("00 80");
    push_char(ChTab);
    push_text("ff");
    push_char(ChCr);
    push_text("7F");
    push_char(ChLf);
    push_text("Ff fF");
    push_char(CH_NUL);
    // idle character, ignored
    push_char("x");
    // third digit fails
    mark_first = 1'b1;
    push_text("123");
    // bad first character fails
    mark_first = 1'b1;
    push_text("G");
    // NUL straight away is a short dump
    mark_first = 1'b1;
    push_char(CH_NUL);
    fill_random(PHASE_ITEMS);

    for (int p = 1; p < 6; p++) begin
      case (p)
        1: scale_pick = 16'hFFFF;
        2: scale_pick = 16'h0000;
        4: scale_pick = 16'h8000;
        default: scale_pick = 16'($urandom_range(65535));
      endcase
      wait_idle();
      apb_write(SCALE_ADDR, scale_pick);
      apb_read_check(SCALE_ADDR);
      if (p == 2) begin
        // write past the last register is dropped
        apb_write(SPARE_ADDR, 16'($urandom));
        apb_read_check(SCALE_ADDR);
      end
      @(negedge clk_i);
      no_gaps = (p == 3);
      fill_random(PHASE_ITEMS);
    end

    wait_idle();
    fail_count += vector_queue.size();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
